// File: rtl/core/pcfr_pkg.sv
// Shared constants, types and CRC-8 functions of the preamble CRC-8 frame receiver.
package pcfr_pkg;

   // CRC-8: polynomial x^8 + x^5 + x^4 + 1, MSB first, no reflection
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Frame positions: length byte first, payload after sender and receiver
   localparam int unsigned POS_W = 9;
   localparam logic [POS_W-1:0] FIRST_FRAME_POS = 9'd4;
   localparam logic [POS_W-1:0] PAYLOAD_START   = 9'd7;

   // Register widths and reset values
   localparam int unsigned PREAMBLE_W = 32;
   localparam int unsigned TICKS_W    = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = 32'h0102_0304;
   localparam logic [TICKS_W-1:0]    TIMEOUT_RESET  = 16'd1000;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_PREAMBLE = 1'b0,
      CSR_TIMEOUT  = 1'b1
   } csr_index_type;

   // Input item codes
   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Configuration as seen by the framer
   typedef struct packed {
      logic [PREAMBLE_W-1:0] preamble_word;
      logic [TICKS_W-1:0]    timeout_ticks;
      logic [7:0]            preamble_crc;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic             byte_valid;
      logic [POS_W-1:0] byte_position;
      logic [7:0]       frame_byte;
      logic             frame_done;
      logic             frame_good;
      logic             received_flag;
      logic             error_flag;
   } rsp_type;

   // Advance the CRC by one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // CRC from the initial value over the four preamble bytes, first byte high
   function automatic logic [7:0] crc8_word(input logic [PREAMBLE_W-1:0] word);
      logic [7:0] c;
      c = CRC_INIT;
      for (int k = 3; k >= 0; k--) begin
         c = crc8_byte(c, word[8*k +: 8]);
      end
      return c;
   endfunction

   localparam logic [7:0] PREAMBLE_CRC_RESET = crc8_word(PREAMBLE_RESET);

endpackage

// File: rtl/core/pcfr_if.sv
// Handshake channel interfaces of the preamble CRC-8 frame receiver.

// Input channel: received bytes and timer ticks
interface pcfr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// Result channel: frame bytes and frame status
interface pcfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         byte_valid;
   logic [pcfr_pkg::POS_W-1:0]   byte_position;
   logic [7:0]                   frame_byte;
   logic                         frame_done;
   logic                         frame_good;
   logic                         received_flag;
   logic                         error_flag;

   modport source (output valid, output byte_valid, output byte_position, output frame_byte,
                   output frame_done, output frame_good, output received_flag,
                   output error_flag, input ready);
   modport sink   (input valid, input byte_valid, input byte_position, input frame_byte,
                   input frame_done, input frame_good, input received_flag,
                   input error_flag, output ready);
endinterface

// Configuration write channel
interface pcfr_csr_if;
   logic                                valid;
   logic                                ready;
   logic                                index;
   logic [pcfr_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/pcfr_csr_regs.sv
// Configuration registers, with the preamble CRC worked out when the preamble is written.
module pcfr_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic                                wr_index,
   input  logic [pcfr_pkg::CSR_DATA_W-1:0]     wr_data,
   output pcfr_pkg::cfg_type                   cfg
);

   logic [pcfr_pkg::PREAMBLE_W-1:0] preamble_ff;
   logic [pcfr_pkg::TICKS_W-1:0]    ticks_ff;
   logic [7:0]                      pcrc_ff;

   // Write on each transfer; unknown indexes cannot occur with a one-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= pcfr_pkg::PREAMBLE_RESET;
         ticks_ff    <= pcfr_pkg::TIMEOUT_RESET;
         pcrc_ff     <= pcfr_pkg::PREAMBLE_CRC_RESET;
      end else if (wr_en) begin
         unique case (pcfr_pkg::csr_index_type'(wr_index))
            pcfr_pkg::CSR_PREAMBLE: begin
               preamble_ff <= wr_data[pcfr_pkg::PREAMBLE_W-1:0];
               pcrc_ff     <= pcfr_pkg::crc8_word(wr_data[pcfr_pkg::PREAMBLE_W-1:0]);
            end
            pcfr_pkg::CSR_TIMEOUT: begin
               ticks_ff <= wr_data[pcfr_pkg::TICKS_W-1:0];
            end
            default: begin
               ticks_ff <= ticks_ff;
            end
         endcase
      end
   end

   assign cfg.preamble_word = preamble_ff;
   assign cfg.timeout_ticks = ticks_ff;
   assign cfg.preamble_crc  = pcrc_ff;

endmodule

// File: rtl/core/pcfr_framer.sv
// Frame state: preamble hunt, byte counting, running CRC, timeout and status flags.
module pcfr_framer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 opcode,
   input  logic [7:0]           rx_byte,
   input  pcfr_pkg::cfg_type    cfg,
   output pcfr_pkg::rsp_type    result
);

   logic [pcfr_pkg::PREAMBLE_W-1:0] hunt_ff, hunt_in;
   logic [pcfr_pkg::POS_W-1:0]      count_ff, count_in;
   logic [7:0]                      len_ff, len_in;
   logic [7:0]                      crc_ff, crc_in;
   logic [pcfr_pkg::TICKS_W-1:0]    tcount_ff, tcount_in;
   logic                            trun_ff, trun_in;
   logic                            good_ff, good_in;
   logic                            bad_ff, bad_in;

   logic [pcfr_pkg::PREAMBLE_W-1:0] hunt_shifted;
   logic [pcfr_pkg::TICKS_W-1:0]    tcount_inc;
   logic [pcfr_pkg::POS_W-1:0]      crc_pos;
   logic                            hunting;

   assign hunting      = (count_ff == '0);
   assign hunt_shifted = {hunt_ff[pcfr_pkg::PREAMBLE_W-9:0], rx_byte};
   assign tcount_inc   = tcount_ff + 1'b1;
   assign crc_pos      = pcfr_pkg::PAYLOAD_START + {1'b0, len_ff};

   // Work out the next state and the result of the current item
   always_comb begin
      hunt_in   = hunt_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      crc_in    = crc_ff;
      tcount_in = tcount_ff;
      trun_in   = trun_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      result    = '0;

      if (pcfr_pkg::opcode_type'(opcode) == pcfr_pkg::OP_TICK) begin
         // Count ticks while a frame is open; abort once the limit is reached
         if (trun_ff) begin
            tcount_in = tcount_inc;
            if (tcount_inc >= cfg.timeout_ticks) begin
               count_in          = '0;
               trun_in           = 1'b0;
               bad_in            = 1'b1;
               result.frame_done = 1'b1;
            end
         end
      end else if (hunting) begin
         // Shift the byte in and look for the preamble
         hunt_in = hunt_shifted;
         if (hunt_shifted == cfg.preamble_word) begin
            crc_in    = cfg.preamble_crc;
            count_in  = pcfr_pkg::FIRST_FRAME_POS;
            good_in   = 1'b0;
            tcount_in = '0;
            trun_in   = 1'b1;
         end
      end else if (count_ff >= pcfr_pkg::PAYLOAD_START && count_ff == crc_pos) begin
         // CRC byte: close the frame and check
         result.frame_done = 1'b1;
         count_in          = '0;
         trun_in           = 1'b0;
         if (crc_ff == rx_byte) begin
            result.frame_good = 1'b1;
            good_in           = 1'b1;
            bad_in            = 1'b0;
         end else begin
            bad_in = 1'b1;
         end
      end else begin
         // Frame byte: pass it out and advance the CRC
         if (count_ff == pcfr_pkg::FIRST_FRAME_POS) begin
            len_in = rx_byte;
         end
         crc_in               = pcfr_pkg::crc8_byte(crc_ff, rx_byte);
         result.byte_valid    = 1'b1;
         result.byte_position = count_ff;
         result.frame_byte    = rx_byte;
         count_in             = count_ff + 1'b1;
      end

      result.received_flag = good_in;
      result.error_flag    = bad_in;
   end

   // Hold state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff   <= '0;
         count_ff  <= '0;
         len_ff    <= '0;
         crc_ff    <= pcfr_pkg::CRC_INIT;
         tcount_ff <= '0;
         trun_ff   <= 1'b0;
         good_ff   <= 1'b0;
         bad_ff    <= 1'b0;
      end else if (accept) begin
         hunt_ff   <= hunt_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         crc_ff    <= crc_in;
         tcount_ff <= tcount_in;
         trun_ff   <= trun_in;
         good_ff   <= good_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

// File: rtl/core/pcfr_rsp_buf.sv
// Two-entry result buffer that registers results and parts input from output stalls.
module pcfr_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcfr_pkg::rsp_type    push_data,
   output logic                 not_full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pcfr_pkg::rsp_type    out_data
);

   pcfr_pkg::rsp_type mem_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic              pop;

   assign not_full  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   // Store pushed results
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/preamble_crc8_frame_receiver.sv
// Top level of the preamble CRC-8 frame receiver.
//
//  Channel   Role   Transfer carries
//  req_chan  sink   opcode (byte or tick), rx_byte
//  rsp_chan  source byte_valid, byte_position, frame_byte, frame_done, frame_good, flags
//  csr_chan  sink   index (0 preamble_word, 1 timeout_ticks), data
//
// One item per clock cycle while req_chan.ready is high; each item gives one result,
// offered from the cycle after its transfer when no older result waits. The frame
// state updates in the cycle of the transfer; the result lands in a two-entry buffer.
// req_chan.ready falls only when both buffer entries wait on rsp_chan.
// Reset is synchronous and active high; csr_chan is always ready.
module preamble_crc8_frame_receiver (
   input  logic              clock,
   input  logic              reset,
   pcfr_req_if.sink          req_chan,
   pcfr_rsp_if.source        rsp_chan,
   pcfr_csr_if.sink          csr_chan
);

   pcfr_pkg::cfg_type cfg;
   pcfr_pkg::rsp_type result;
   pcfr_pkg::rsp_type out_data;
   logic              buf_not_full;
   logic              req_accept;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = buf_not_full;
   assign req_accept     = req_chan.valid && buf_not_full;

   pcfr_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   pcfr_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .opcode  (req_chan.opcode),
      .rx_byte (req_chan.rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   pcfr_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (result),
      .not_full  (buf_not_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.byte_valid    = out_data.byte_valid;
   assign rsp_chan.byte_position = out_data.byte_position;
   assign rsp_chan.frame_byte    = out_data.frame_byte;
   assign rsp_chan.frame_done    = out_data.frame_done;
   assign rsp_chan.frame_good    = out_data.frame_good;
   assign rsp_chan.received_flag = out_data.received_flag;
   assign rsp_chan.error_flag    = out_data.error_flag;

   // An accepted item always shows a result in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_chan.valid)
      else $error("no result after an input transfer");

   // Input back-pressure only while results are waiting
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with no result waiting");

   // Received and error flags never both set
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.received_flag && rsp_chan.error_flag))
      else $error("received and error flags both set");

endmodule
